FILE: hdl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hdl/b32e_pkg.sv
// Types, constants and the symbol alphabet of the Base32 stream encoder.
`timescale 1ns / 1ps
`default_nettype none

package b32e_pkg;

  localparam int SYM_W     = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [6:0] PAD_CHAR = 7'h3D;

  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_CASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_ENABLE = 2'd1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic       last_char;
  } out_t;

  // One classified byte: symbols to send, then pad characters.
  typedef struct packed {
    logic [2:0][SYM_W-1:0] sym;
    logic [1:0]            nsym;
    logic [2:0]            last_idx;
    logic                  fin;
  } job_t;

  // Map a 5-bit symbol value to its ASCII character.
  function automatic logic [6:0] sym_char(input logic [SYM_W-1:0] v, input logic lower);
    logic [6:0] base;
    base = lower ? 7'd97 : 7'd65;
    if (v < 5'd26) begin
      return base + {2'b00, v};
    end else begin
      return 7'd24 + {2'b00, v};
    end
  endfunction

endpackage

`default_nettype wire

FILE: hdl/b32e_front.sv
// Front end: tracks group position and carry, turns each byte into a job.
`timescale 1ns / 1ps
`default_nettype none

module b32e_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire b32e_pkg::in_t in_beat,
  input  wire logic          pad_enable,
  output b32e_pkg::job_t     job
);
  import b32e_pkg::*;

  logic [3:0]       carry_bits;
  logic [3:0]       carry_bits_next;
  logic [2:0]       group_position;
  logic [2:0]       group_position_next;
  logic [7:0]       b;
  logic [3:0]       nc;
  logic [SYM_W-1:0] s0;
  logic [SYM_W-1:0] s1;
  logic [SYM_W-1:0] flush;
  logic             has_flush;
  logic [1:0]       nsym;
  logic [2:0]       npad;
  logic [2:0]       pos_inc;
  logic [1:0]       nsym_all;
  logic [2:0]       pad_used;

  assign b = in_beat.data_byte;

  // Split the byte by its place in the five-byte group
  always_comb begin
    s1        = '0;
    has_flush = 1'b1;
    case (group_position)
      3'd1: begin
        s0 = {carry_bits[2:0], b[7:6]};
        s1 = b[5:1];
        nc = {3'b000, b[0]};
        flush = {b[0], 4'b0000};
        nsym = 2'd2; npad = 3'd4; pos_inc = 3'd2;
      end
      3'd2: begin
        s0 = {carry_bits[0], b[7:4]};
        nc = b[3:0];
        flush = {b[3:0], 1'b0};
        nsym = 2'd1; npad = 3'd3; pos_inc = 3'd3;
      end
      3'd3: begin
        s0 = {carry_bits[3:0], b[7]};
        s1 = b[6:2];
        nc = {2'b00, b[1:0]};
        flush = {b[1:0], 3'b000};
        nsym = 2'd2; npad = 3'd1; pos_inc = 3'd4;
      end
      3'd4: begin
        s0 = {carry_bits[1:0], b[7:5]};
        s1 = b[4:0];
        nc = 4'd0;
        flush = '0;
        has_flush = 1'b0;
        nsym = 2'd2; npad = 3'd0; pos_inc = 3'd0;
      end
      default: begin
        s0 = b[7:3];
        nc = {1'b0, b[2:0]};
        flush = {b[2:0], 2'b00};
        nsym = 2'd1; npad = 3'd6; pos_inc = 3'd1;
      end
    endcase
  end

  // Append any flush symbol, and padding if enabled, on the final byte
  always_comb begin
    job.sym[0] = s0;
    job.sym[1] = s1;
    job.sym[2] = flush;
    nsym_all   = nsym;
    pad_used   = 3'd0;
    if (in_beat.final_byte) begin
      if (has_flush) begin
        if (nsym == 2'd1) begin
          job.sym[1] = flush;
        end
        nsym_all = nsym + 2'd1;
      end
      if (pad_enable) begin
        pad_used = npad;
      end
    end
    job.nsym     = nsym_all;
    job.last_idx = {1'b0, nsym_all} + pad_used - 3'd1;
    job.fin      = in_beat.final_byte;
  end

  // Advance position and carry; restart after a final byte
  always_comb begin
    carry_bits_next     = carry_bits;
    group_position_next = group_position;
    if (accept) begin
      if (in_beat.final_byte) begin
        carry_bits_next     = '0;
        group_position_next = '0;
      end else begin
        carry_bits_next     = nc;
        group_position_next = pos_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carry_bits     <= '0;
      group_position <= '0;
    end else begin
      carry_bits     <= carry_bits_next;
      group_position <= group_position_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/b32e_jobq.sv
// Two-entry job queue between the front end and the character sequencer.
`timescale 1ns / 1ps
`default_nettype none

module b32e_jobq (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr,
  input  wire b32e_pkg::job_t wr_job,
  output logic                full,
  input  wire logic           rd,
  output b32e_pkg::job_t      head,
  output logic                avail
);
  import b32e_pkg::*;

  job_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign avail = (count != 2'd0);
  assign head  = mem[rd_ptr];

  // Store the job at the write pointer
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

`default_nettype wire

FILE: hdl/b32e_back.sv
// Back end: job characters enter an output queue, one per cycle unless it is full.
`timescale 1ns / 1ps
`default_nettype none

module b32e_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire b32e_pkg::job_t job,
  input  wire logic           job_avail,
  output logic                job_done,
  input  wire logic           lower_case,
  input  wire logic           pop,
  output logic                empty,
  output b32e_pkg::out_t      out_data
);
  import b32e_pkg::*;

  out_t       oq [2];
  logic       oq_wr_ptr;
  logic       oq_rd_ptr;
  logic [1:0] oq_count;
  logic       oq_full;
  logic       emit;
  logic       oq_rd;
  logic [2:0] idx;
  logic [2:0] idx_next;
  logic       at_last;
  out_t       beat;

  assign oq_full  = (oq_count == 2'd2);
  assign empty    = (oq_count == 2'd0);
  assign oq_rd    = pop && !empty;
  assign out_data = oq[oq_rd_ptr];

  assign emit     = job_avail && !oq_full;
  assign at_last  = (idx == job.last_idx);
  assign job_done = emit && at_last;

  // Pick a symbol character or a pad character
  always_comb begin
    if (idx < {1'b0, job.nsym}) begin
      beat.char_code = sym_char(job.sym[idx[1:0]], lower_case);
    end else begin
      beat.char_code = PAD_CHAR;
    end
    beat.last_char = job.fin && at_last;
  end

  // Step through the job; restart at the next one
  always_comb begin
    idx_next = idx;
    if (emit) begin
      idx_next = at_last ? 3'd0 : idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      oq[oq_wr_ptr] <= beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 3'd0;
      oq_wr_ptr <= 1'b0;
      oq_rd_ptr <= 1'b0;
      oq_count  <= 2'd0;
    end else begin
      idx <= idx_next;
      if (emit) begin
        oq_wr_ptr <= ~oq_wr_ptr;
      end
      if (oq_rd) begin
        oq_rd_ptr <= ~oq_rd_ptr;
      end
      oq_count <= oq_count + {1'b0, emit} - {1'b0, oq_rd};
    end
  end

endmodule

`default_nettype wire

FILE: hdl/base32_stream_encoder.sv
// Data path: an accepted byte is registered as a job in the job queue, and the
// sequencer registers its characters in the output queue, one per cycle while a
// job waits and that queue has room. A byte gives 1 to 2 characters, a final byte
// up to 8 (flush plus padding); the job queue holds two bytes. Reset: synchronous,
// clears position, carry, both queues; lower_case returns to 0, pad_enable to 1.
`timescale 1ns / 1ps
`default_nettype none

module base32_stream_encoder (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              push,
  output logic                                   full,
  input  wire b32e_pkg::in_t                     in_data,
  input  wire logic                              pop,
  output logic                                   empty,
  output b32e_pkg::out_t                         out_data,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [b32e_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic                              cfg_data
);
  import b32e_pkg::*;

  logic lower_case;
  logic pad_enable;
  logic accept;
  job_t new_job;
  job_t head_job;
  logic job_avail;
  logic job_done;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  // Hold the configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lower_case <= 1'b0;
      pad_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LOWER_CASE: lower_case <= cfg_data;
        CFG_PAD_ENABLE: pad_enable <= cfg_data;
        default: ;
      endcase
    end
  end

  b32e_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .in_beat    (in_data),
    .pad_enable (pad_enable),
    .job        (new_job)
  );

  b32e_jobq u_jobq (
    .clk    (clk),
    .rst    (rst),
    .wr     (accept),
    .wr_job (new_job),
    .full   (full),
    .rd     (job_done),
    .head   (head_job),
    .avail  (job_avail)
  );

  b32e_back u_back (
    .clk        (clk),
    .rst        (rst),
    .job        (head_job),
    .job_avail  (job_avail),
    .job_done   (job_done),
    .lower_case (lower_case),
    .pop        (pop),
    .empty      (empty),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

FILE: hdl/b32e_checker.sv
// Port-level checker for the Base32 stream encoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module b32e_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           full,
  input wire logic           pop,
  input wire logic           empty,
  input wire b32e_pkg::out_t out_data,
  input wire logic           cfg_ready
);
  import b32e_pkg::*;

  logic [6:0] c;
  logic       c_ok;
  assign c = out_data.char_code;

  // Accept letters of either alphabet, the digits 2 to 7, and the pad character
  assign c_ok = (c >= 7'd65 && c <= 7'd90) || (c >= 7'd97 && c <= 7'd122) ||
                (c >= 7'd50 && c <= 7'd55) || (c == PAD_CHAR);

  `ASSERT_ALWAYS(a_reset_empty, clk, rst |=> (empty && !full), "queues not empty after reset")
  `ASSERT_CLK(a_char_set, clk, rst, !empty |-> c_ok, "character outside the Base32 set")
  `ASSERT_CLK(a_out_hold, clk, rst, (!empty && !pop) |=> (!empty && $stable(out_data)), "waiting character changed")
  `ASSERT_CLK(a_cfg_ready, clk, rst, cfg_ready, "configuration port not ready")

endmodule

bind base32_stream_encoder b32e_checker u_b32e_checker (
  .clk       (clk),
  .rst       (rst),
  .full      (full),
  .pop       (pop),
  .empty     (empty),
  .out_data  (out_data),
  .cfg_ready (cfg_ready)
);

`default_nettype wire

FILE: test/base32_stream_encoder_tb.sv
// Self-checking testbench for the Base32 stream encoder: random messages, register sweeps.
`timescale 1ns / 1ps

module base32_stream_encoder_tb;
  import b32e_pkg::*;

  localparam int IDLE_PCT           = 17;
  localparam int RESET_CYCLES       = 12;
  localparam int RECV_STALL_CYCLES  = 300;
  localparam int TAIL_CYCLES        = 20;
  localparam int MAX_REPORTS        = 10;
  localparam int PHASE_ITEMS        = 100;
  localparam longint TIMEOUT_NS     = 400_000;
  localparam int GROUP_CHARS        = 8;

  // Indexes outside the register map; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 push      = 1'b0;
  logic                 full;
  in_t                  in_data   = '0;
  logic                 pop       = 1'b0;
  logic                 empty;
  out_t                 out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic                 cfg_data  = 1'b0;

  // Bytes waiting to be offered, characters waiting to be seen.
  in_t  pending_bytes[$];
  out_t expected_chars[$];

  // Predictor copy of the registers and the encoder state.
  logic       opt_lower = 1'b0;
  logic       opt_pad   = 1'b1;
  logic [3:0] enc_carry = '0;
  logic [2:0] enc_pos   = '0;

  // Run control shared with the driver and the monitor.
  bit calm         = 1'b0;
  bit stall_armed  = 1'b0;
  bit stall_done   = 1'b0;
  int stall_count  = 0;

  int mismatch_count    = 0;
  int bytes_sent        = 0;
  int chars_checked     = 0;
  int messages_queued   = 0;
  int full_stall_cycles = 0;
  int settings_used     = 1;

  base32_stream_encoder DUT (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .pop       (pop),
    .empty     (empty),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Map a 5-bit symbol to its character in the selected alphabet.
  function automatic out_t symbol_char(input logic [4:0] sym);
    out_t ch;
    ch.last_char = 1'b0;
    if (sym < 5'd26) begin
      ch.char_code = (opt_lower ? 7'h61 : 7'h41) + 7'(sym);
    end else begin
      ch.char_code = 7'h32 + 7'(sym - 5'd26);
    end
    return ch;
  endfunction

  // Work out the characters one accepted byte produces and queue them.
  task automatic predict_byte(input in_t item);
    logic [7:0] b;
    logic [3:0] c;
    logic [4:0] flush_sym;
    bit         has_flush;
    int         group_len;
    out_t       chars[$];
    out_t       pad_ch;
    b         = item.data_byte;
    c         = enc_carry;
    has_flush = 1'b1;
    flush_sym = '0;
    pad_ch.char_code = PAD_CHAR;
    pad_ch.last_char = 1'b0;
    case (enc_pos)
      3'd1: begin
        chars = {chars, symbol_char({c[2:0], b[7:6]})};
        chars = {chars, symbol_char(b[5:1])};
        c = {3'b000, b[0]};
        flush_sym = {b[0], 4'b0000};
        group_len = 4;
      end
      3'd2: begin
        chars = {chars, symbol_char({c[0], b[7:4]})};
        c = b[3:0];
        flush_sym = {b[3:0], 1'b0};
        group_len = 5;
      end
      3'd3: begin
        chars = {chars, symbol_char({c[3:0], b[7]})};
        chars = {chars, symbol_char(b[6:2])};
        c = {2'b00, b[1:0]};
        flush_sym = {b[1:0], 3'b000};
        group_len = 7;
      end
      3'd4: begin
        chars = {chars, symbol_char({c[1:0], b[7:5]})};
        chars = {chars, symbol_char(b[4:0])};
        c = '0;
        has_flush = 1'b0;
        group_len = GROUP_CHARS;
      end
      default: begin
        // start of group; an out-of-range position counts as the start too
        chars = {chars, symbol_char(b[7:3])};
        c = {1'b0, b[2:0]};
        flush_sym = {b[2:0], 2'b00};
        group_len = 2;
      end
    endcase
    if (item.final_byte) begin
      if (has_flush) chars = {chars, symbol_char(flush_sym)};
      if (opt_pad) begin
        while (group_len < GROUP_CHARS) begin
          chars = {chars, pad_ch};
          group_len++;
        end
      end
      chars[chars.size()-1].last_char = 1'b1;
      enc_carry = '0;
      enc_pos   = '0;
    end else begin
      enc_carry = c;
      enc_pos   = (enc_pos >= 3'd4) ? 3'd0 : enc_pos + 3'd1;
    end
    expected_chars = {expected_chars, chars};
  endtask

  task automatic note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("mismatch: %s", msg);
  endtask

  // Compare one popped character with the oldest expectation.
  task automatic check_char(input out_t got);
    out_t want;
    if (expected_chars.size() == 0) begin
      note_failure($sformatf("unexpected character 0x%02h last=%0b",
                             got.char_code, got.last_char));
    end else begin
      want = expected_chars.pop_front();
      chars_checked++;
      if (got.char_code !== want.char_code)
        note_failure($sformatf("char #%0d code: expected 0x%02h got 0x%02h",
                               chars_checked, want.char_code, got.char_code));
      if (got.last_char !== want.last_char)
        note_failure($sformatf("char #%0d last: expected %0b got %0b",
                               chars_checked, want.last_char, got.last_char));
    end
  endtask

  // Byte driver: offer queued bytes, hold while full, idle at random.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (push && full) begin
      full_stall_cycles++;
    end else begin
      if (push) begin
        predict_byte(in_data);
        bytes_sent++;
        void'(pending_bytes.pop_front());
      end
      if (pending_bytes.size() != 0 && (calm || $urandom_range(99, 0) >= IDLE_PCT)) begin
        push    <= 1'b1;
        in_data <= pending_bytes[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Character monitor: check each popped beat, stall once for a long stretch.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_char(out_data);
      if (stall_armed && !stall_done) begin
        stall_count++;
        if (stall_count >= RECV_STALL_CYCLES) stall_done = 1'b1;
        pop <= 1'b0;
      end else begin
        pop <= calm || ($urandom_range(99, 0) >= IDLE_PCT);
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_LOWER_CASE: opt_lower = val;
      CFG_PAD_ENABLE: opt_pad   = val;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || push || expected_chars.size() != 0)
      @(negedge clk);
  endtask

  task automatic set_options(input logic lower, input logic pad);
    wait_drained();
    write_reg(CFG_LOWER_CASE, lower);
    write_reg(CFG_PAD_ENABLE, pad);
    settings_used++;
  endtask

  // Queue whole messages with random content; now and then a loose run of
  // bytes with final flags at random.
  task automatic queue_random_messages(input int item_budget);
    int   left;
    int   len;
    bit   loose;
    in_t  item;
    left = item_budget;
    @(negedge clk);
    while (left > 0) begin
      len   = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 11) : $urandom_range(10, 1);
      loose = ($urandom_range(9, 0) == 0);
      for (int k = 0; k < len; k++) begin
        case ($urandom_range(7, 0))
          0:       item.data_byte = 8'h00;
          1:       item.data_byte = 8'hFF;
          default: item.data_byte = 8'($urandom_range(255, 0));
        endcase
        item.final_byte = loose ? ($urandom_range(2, 0) == 0) : (k == len - 1);
        pending_bytes = {pending_bytes, item};
      end
      if (!loose) messages_queued++;
      left -= len;
    end
  endtask

  initial begin
    logic [7:0] directed_bytes [21];
    in_t        item;
    int         idx;
    directed_bytes = '{8'hFF,
                       8'h00, 8'hFF,
                       8'hFF, 8'h00, 8'hAA,
                       8'h55, 8'hFF, 8'h00, 8'hFF,
                       8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                       8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hAA};

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed: messages of one to six bytes under the reset settings, so
    // every final position is hit, the complete group among them.
    @(negedge clk);
    idx = 0;
    for (int len = 1; len <= 6; len++) begin
      for (int k = 0; k < len; k++) begin
        item.data_byte  = directed_bytes[idx];
        item.final_byte = (k == len - 1);
        pending_bytes = {pending_bytes, item};
        idx++;
      end
      messages_queued++;
    end

    // Lowercase with padding; spare indexes must leave both registers alone.
    set_options(1'b1, 1'b1);
    write_reg(CFG_SPARE_2, 1'b0);
    write_reg(CFG_SPARE_3, 1'b0);
    write_reg(CFG_SPARE_2, 1'b1);
    queue_random_messages(PHASE_ITEMS);

    // Uppercase without padding, both sides running flat out.
    set_options(1'b0, 1'b0);
    @(negedge clk);
    calm = 1'b1;
    queue_random_messages(PHASE_ITEMS);
    wait_drained();
    @(negedge clk);
    calm = 1'b0;

    // Lowercase without padding; the receiver holds off once for a long stretch, so the input backs up.
    set_options(1'b1, 1'b0);
    queue_random_messages(PHASE_ITEMS);
    stall_armed = 1'b1;

    // Back to the reset settings.
    set_options(1'b0, 1'b1);
    queue_random_messages(PHASE_ITEMS);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d bytes in %0d whole messages, %0d characters checked",
             bytes_sent, messages_queued, chars_checked);
    $display("%0d register settings, input held off for %0d cycles, %0d mismatches",
             settings_used, full_stall_cycles, mismatch_count);
    if (mismatch_count == 0 && expected_chars.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout: %0d bytes pending, %0d characters still expected",
             pending_bytes.size(), expected_chars.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/b32e_pkg.sv
hdl/b32e_front.sv
hdl/b32e_jobq.sv
hdl/b32e_back.sv
hdl/base32_stream_encoder.sv
hdl/b32e_checker.sv
test/base32_stream_encoder_tb.sv
